>>> src/em4mfd_pkg.sv
package em4mfd_pkg;

    localparam int TIME_W  = 48;
    localparam int LIMIT_W = 32;
    localparam int TAG_W   = 40;
    localparam int NIB_W   = 4;
    localparam int KIND_W  = 3;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] HALF_LIMIT_RST = LIMIT_W'(384);

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_BIT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VERSION = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DATA    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRAILER = 3'd4;

    localparam logic [3:0] HEADER_ONES     = 4'd9;
    localparam logic [5:0] VERSION_BITS    = 6'd10;
    localparam logic [5:0] PAYLOAD_BITS    = 6'd50;
    localparam logic [2:0] ROW_BITS        = 3'd5;
    localparam logic [2:0] COL_BITS        = 3'd4;

    typedef struct packed {
        logic              fire;
        logic              bit_value;
        logic [TIME_W-1:0] bit_start;
        logic [TIME_W-1:0] bit_end;
    } t_bit_evt;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [NIB_W-1:0]  nibble;
        logic              row_parity_good;
        logic [NIB_W-1:0]  column_parity_good;
        logic [TAG_W-1:0]  tag_value;
        logic              tag_valid;
    } t_frame_res;

endpackage

>>> src/em4mfd_edge.sv
module em4mfd_edge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [em4mfd_pkg::TIME_W-1:0]     i_time,
    input  logic                              i_level,
    input  logic [em4mfd_pkg::LIMIT_W-1:0]    i_half_limit,
    input  logic                              i_polarity,
    output em4mfd_pkg::t_bit_evt              o_evt
);

    localparam int TW = em4mfd_pkg::TIME_W;

    logic [TW-1:0] r_last_time;
    logic [TW-1:0] r_last_int;
    logic [TW-1:0] r_prev_start;
    logic [TW-1:0] r_prev_mid;
    logic [TW-1:0] r_last_pos;

    logic [TW-1:0] pulse_len;
    logic [TW-1:0] limit_ext;
    logic [TW-1:0] mid_now;
    logic          long_now;
    logic          long_prev;
    logic [TW-1:0] n_last_pos;

    assign limit_ext = {{(TW - em4mfd_pkg::LIMIT_W){1'b0}}, i_half_limit};
    assign pulse_len = i_time - r_last_time;
    assign mid_now   = i_time - (pulse_len >> 1);
    assign long_now  = pulse_len > limit_ext;
    assign long_prev = r_last_int > limit_ext;

    always_comb begin
        o_evt.bit_value = i_polarity ? i_level : ~i_level;
        o_evt.fire      = 1'b0;
        o_evt.bit_start = r_prev_start;
        o_evt.bit_end   = i_time;
        n_last_pos      = r_last_pos;
        if (long_now) begin
            o_evt.fire      = 1'b1;
            o_evt.bit_start = long_prev ? r_prev_mid : r_prev_start;
            o_evt.bit_end   = mid_now;
            n_last_pos      = mid_now;
        end else if (long_prev) begin
            o_evt.fire      = 1'b1;
            o_evt.bit_start = r_prev_mid;
            n_last_pos      = i_time;
        end else if (r_last_pos <= r_prev_start) begin
            o_evt.fire      = 1'b1;
            n_last_pos      = i_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_last_int   <= '0;
            r_prev_start <= '0;
            r_prev_mid   <= '0;
            r_last_pos   <= '0;
        end else if (i_step) begin
            r_last_time  <= i_time;
            r_last_int   <= pulse_len;
            r_prev_start <= r_last_time;
            r_prev_mid   <= mid_now;
            r_last_pos   <= n_last_pos;
        end
    end

endmodule

>>> src/em4mfd_frame.sv
module em4mfd_frame (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic                   i_bit,
    output em4mfd_pkg::t_frame_res o_res
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    t_phase                            r_phase,    n_phase;
    logic [3:0]                        r_ones,     n_ones;
    logic [5:0]                        r_frame_cnt, n_frame_cnt;
    logic [2:0]                        r_grp_cnt,  n_grp_cnt;
    logic [3:0]                        r_row,      n_row;
    logic                              r_row_par,  n_row_par;
    logic [3:0]                        r_col_acc,  n_col_acc;
    logic [3:0]                        r_col_rx,   n_col_rx;
    logic                              r_rows_good, n_rows_good;
    logic [em4mfd_pkg::TAG_W-1:0]      r_tag,      n_tag;

    logic [5:0] fc_inc;
    logic [2:0] g_inc;
    logic [1:0] col_sel;
    logic [3:0] row_eff;
    logic       par_eff;
    logic [3:0] col_good;

    assign fc_inc  = r_frame_cnt + 6'd1;
    assign g_inc   = r_grp_cnt + 3'd1;
    assign col_sel = r_grp_cnt[1:0];
    assign row_eff = (r_grp_cnt == 3'd0) ? 4'd0 : r_row;
    assign par_eff = (r_grp_cnt == 3'd0) ? 1'b0 : r_row_par;
    assign col_good = ~(r_col_acc ^ r_col_rx);

    always_comb begin
        n_phase     = r_phase;
        n_ones      = r_ones;
        n_frame_cnt = r_frame_cnt;
        n_grp_cnt   = r_grp_cnt;
        n_row       = r_row;
        n_row_par   = r_row_par;
        n_col_acc   = r_col_acc;
        n_col_rx    = r_col_rx;
        n_rows_good = r_rows_good;
        n_tag       = r_tag;
        o_res       = '0;
        o_res.event_kind = em4mfd_pkg::KIND_BIT;
        unique case (r_phase)
            PH_PAYLOAD: begin
                n_frame_cnt = fc_inc;
                if (g_inc >= em4mfd_pkg::ROW_BITS) begin
                    o_res.nibble          = row_eff;
                    o_res.row_parity_good = (par_eff == i_bit);
                    if (par_eff != i_bit) begin
                        n_rows_good = 1'b0;
                    end
                    n_tag = {r_tag[em4mfd_pkg::TAG_W-em4mfd_pkg::NIB_W-1:0], row_eff};
                    o_res.tag_value  = n_tag;
                    o_res.event_kind = (fc_inc <= em4mfd_pkg::VERSION_BITS) ?
                                       em4mfd_pkg::KIND_VERSION : em4mfd_pkg::KIND_DATA;
                    n_row     = row_eff;
                    n_row_par = par_eff;
                    n_grp_cnt = 3'd0;
                    if (fc_inc >= em4mfd_pkg::PAYLOAD_BITS) begin
                        n_phase     = PH_TRAILER;
                        n_frame_cnt = 6'd0;
                    end
                end else begin
                    n_row_par = par_eff ^ i_bit;
                    n_col_acc = r_col_acc ^ ({3'd0, i_bit} << col_sel);
                    n_row     = {row_eff[2:0], i_bit};
                    n_grp_cnt = g_inc;
                end
            end
            PH_TRAILER: begin
                n_frame_cnt = fc_inc;
                if (g_inc <= em4mfd_pkg::COL_BITS) begin
                    n_col_rx          = r_col_rx;
                    n_col_rx[col_sel] = i_bit;
                    n_grp_cnt         = g_inc;
                end else begin
                    o_res.column_parity_good = col_good;
                    o_res.tag_valid  = (col_good == 4'hF) && r_rows_good;
                    o_res.tag_value  = r_tag;
                    o_res.event_kind = em4mfd_pkg::KIND_TRAILER;
                    n_tag       = '0;
                    n_grp_cnt   = 3'd0;
                    n_phase     = PH_HEADER;
                    n_frame_cnt = 6'd0;
                    n_col_acc   = 4'd0;
                    n_col_rx    = 4'd0;
                    n_rows_good = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HEADER;
                if (i_bit) begin
                    if (r_ones == em4mfd_pkg::HEADER_ONES - 4'd1) begin
                        o_res.event_kind = em4mfd_pkg::KIND_HEADER;
                        n_ones  = 4'd0;
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_ones = r_ones + 4'd1;
                    end
                end else begin
                    n_ones = 4'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_ones      <= '0;
            r_frame_cnt <= '0;
            r_grp_cnt   <= '0;
            r_row       <= '0;
            r_row_par   <= 1'b0;
            r_col_acc   <= '0;
            r_col_rx    <= '0;
            r_rows_good <= 1'b1;
            r_tag       <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_ones      <= n_ones;
            r_frame_cnt <= n_frame_cnt;
            r_grp_cnt   <= n_grp_cnt;
            r_row       <= n_row;
            r_row_par   <= n_row_par;
            r_col_acc   <= n_col_acc;
            r_col_rx    <= n_col_rx;
            r_rows_good <= n_rows_good;
            r_tag       <= n_tag;
        end
    end

endmodule

>>> src/em4100_manchester_frame_decoder_core.sv
// channel   direction  handshake                  payload
// edge in   input      i_in_valid / o_in_ready    i_edge_time, i_new_level
// result    output     o_out_valid / i_out_ready  bit, span, event, nibble, parity, tag
// config    input      i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
// one edge per cycle sustained while no result is held; a result leaves through two registers after its edge transfer
// (input register, then decode logic into the result register)
// edges that complete no bit produce no result but still pass through the input register
// synchronous active-low reset returns limit 384, active-high polarity, header search
// a held result stalls the input register, which then stalls the edge channel
module em4100_manchester_frame_decoder_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [em4mfd_pkg::TIME_W-1:0]         i_edge_time,
    input  logic                                  i_new_level,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_bit_value,
    output logic [em4mfd_pkg::TIME_W-1:0]         o_bit_start,
    output logic [em4mfd_pkg::TIME_W-1:0]         o_bit_end,
    output logic [em4mfd_pkg::KIND_W-1:0]         o_event_kind,
    output logic [em4mfd_pkg::NIB_W-1:0]          o_nibble,
    output logic                                  o_row_parity_good,
    output logic [em4mfd_pkg::NIB_W-1:0]          o_column_parity_good,
    output logic [em4mfd_pkg::TAG_W-1:0]          o_tag_value,
    output logic                                  o_tag_valid,
    input  logic                                  i_cfg_wr_en,
    input  logic [em4mfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [em4mfd_pkg::CFG_W-1:0]          i_cfg_wdata
);

    logic [em4mfd_pkg::LIMIT_W-1:0] r_half_limit;
    logic                           r_polarity;

    logic                           r_in_valid;
    logic [em4mfd_pkg::TIME_W-1:0]  r_in_time;
    logic                           r_in_level;

    logic                           r_out_valid;
    em4mfd_pkg::t_bit_evt           r_out_evt;
    em4mfd_pkg::t_frame_res         r_out_res;

    logic                           advance;
    em4mfd_pkg::t_bit_evt           bit_evt;
    em4mfd_pkg::t_frame_res         frame_res;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    em4mfd_edge u_edge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_time       (r_in_time),
        .i_level      (r_in_level),
        .i_half_limit (r_half_limit),
        .i_polarity   (r_polarity),
        .o_evt        (bit_evt)
    );

    em4mfd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance && bit_evt.fire),
        .i_bit   (bit_evt.bit_value),
        .o_res   (frame_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_limit <= em4mfd_pkg::HALF_LIMIT_RST;
            r_polarity   <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                em4mfd_pkg::CFG_HALF_LIMIT: r_half_limit <= i_cfg_wdata[em4mfd_pkg::LIMIT_W-1:0];
                em4mfd_pkg::CFG_POLARITY:   r_polarity   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_time  <= i_edge_time;
            r_in_level <= i_new_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && bit_evt.fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && bit_evt.fire) begin
            r_out_evt <= bit_evt;
            r_out_res <= frame_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_bit_value          = r_out_evt.bit_value;
    assign o_bit_start          = r_out_evt.bit_start;
    assign o_bit_end            = r_out_evt.bit_end;
    assign o_event_kind         = r_out_res.event_kind;
    assign o_nibble             = r_out_res.nibble;
    assign o_row_parity_good    = r_out_res.row_parity_good;
    assign o_column_parity_good = r_out_res.column_parity_good;
    assign o_tag_value          = r_out_res.tag_value;
    assign o_tag_valid          = r_out_res.tag_valid;

    a_ready_only_when_empty_or_moving: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready)
    ) else $error("input stalled without a held result");

    a_nibble_only_on_rows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind != em4mfd_pkg::KIND_VERSION
            && o_event_kind != em4mfd_pkg::KIND_DATA)
        |-> (o_nibble == '0 && !o_row_parity_good)
    ) else $error("nibble fields set outside a row event");

    a_tag_valid_on_trailer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tag_valid)
        |-> (o_event_kind == em4mfd_pkg::KIND_TRAILER && o_column_parity_good == 4'hF)
    ) else $error("tag flagged valid outside a clean trailer");

    a_result_needs_step: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(advance)
    ) else $error("result appeared without a decoded edge");

endmodule

>>> tb/em4100_frame_checker.sv
module em4100_frame_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [em4mfd_pkg::TIME_W-1:0]      i_edge_time,
    input  logic                               i_new_level,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic                               i_bit_value,
    input  logic [em4mfd_pkg::TIME_W-1:0]      i_bit_start,
    input  logic [em4mfd_pkg::TIME_W-1:0]      i_bit_end,
    input  logic [em4mfd_pkg::KIND_W-1:0]      i_event_kind,
    input  logic [em4mfd_pkg::NIB_W-1:0]       i_nibble,
    input  logic                               i_row_parity_good,
    input  logic [em4mfd_pkg::NIB_W-1:0]       i_column_parity_good,
    input  logic [em4mfd_pkg::TAG_W-1:0]       i_tag_value,
    input  logic                               i_tag_valid,
    input  logic                               i_cfg_wr_en,
    input  logic [em4mfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [em4mfd_pkg::CFG_W-1:0]       i_cfg_wdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        SEEK_HEADER = 2'd0,
        IN_PAYLOAD  = 2'd1,
        IN_TRAILER  = 2'd2
    } t_frame_phase;

    typedef struct packed {
        logic                          bit_value;
        logic [em4mfd_pkg::TIME_W-1:0] bit_start;
        logic [em4mfd_pkg::TIME_W-1:0] bit_end;
        logic [em4mfd_pkg::KIND_W-1:0] event_kind;
        logic [em4mfd_pkg::NIB_W-1:0]  nibble;
        logic                          row_parity_good;
        logic [em4mfd_pkg::NIB_W-1:0]  column_parity_good;
        logic [em4mfd_pkg::TAG_W-1:0]  tag_value;
        logic                          tag_valid;
    } t_decoded_bit;

    t_decoded_bit bits_due[$];
    t_decoded_bit got;
    t_decoded_bit want;

    logic [em4mfd_pkg::LIMIT_W-1:0] limit_reg;
    logic                           pol_reg;
    logic [em4mfd_pkg::TIME_W-1:0]  prev_edge_t;
    logic [em4mfd_pkg::TIME_W-1:0]  prev_gap;
    logic [em4mfd_pkg::TIME_W-1:0]  last_bit_end;
    t_frame_phase                   phase;
    logic [3:0]                     ones_seen;
    logic [5:0]                     frame_bits;
    logic [2:0]                     group_bits;
    logic [3:0]                     row_bits;
    logic                           row_par;
    logic [3:0]                     col_par_calc;
    logic [3:0]                     col_par_rx;
    logic                           rows_ok;
    logic [em4mfd_pkg::TAG_W-1:0]   tag_acc;

    int fails = 0;
    int reported = 0;

    function automatic void show(input string what, input t_decoded_bit d);
        $display("%s: bit %0b start %h end %h kind %0d nib %h rp %0b cp %h tag %h tv %0b",
                 what, d.bit_value, d.bit_start, d.bit_end, d.event_kind, d.nibble,
                 d.row_parity_good, d.column_parity_good, d.tag_value, d.tag_valid);
    endfunction

    // frames one decoded bit and queues the result it produces
    task automatic frame_bit(input logic b, input logic [em4mfd_pkg::TIME_W-1:0] ss,
                             input logic [em4mfd_pkg::TIME_W-1:0] es);
        t_decoded_bit r;
        r = '0;
        r.bit_value = b;
        r.bit_start = ss;
        r.bit_end = es;
        r.event_kind = em4mfd_pkg::KIND_BIT;
        case (phase)
            IN_PAYLOAD: begin
                frame_bits = frame_bits + 6'd1;
                if (group_bits == 3'd0) begin
                    row_bits = '0;
                    row_par = 1'b0;
                end
                group_bits = group_bits + 3'd1;
                if (group_bits >= em4mfd_pkg::ROW_BITS) begin
                    r.nibble = row_bits;
                    r.row_parity_good = (row_par == b);
                    if (row_par != b)
                        rows_ok = 1'b0;
                    tag_acc = {tag_acc[em4mfd_pkg::TAG_W-5:0], row_bits};
                    r.tag_value = tag_acc;
                    r.event_kind = (frame_bits <= em4mfd_pkg::VERSION_BITS) ?
                                   em4mfd_pkg::KIND_VERSION : em4mfd_pkg::KIND_DATA;
                    group_bits = 3'd0;
                    if (frame_bits >= em4mfd_pkg::PAYLOAD_BITS) begin
                        phase = IN_TRAILER;
                        frame_bits = 6'd0;
                    end
                end else begin
                    row_par = row_par ^ b;
                    col_par_calc[group_bits - 3'd1] = col_par_calc[group_bits - 3'd1] ^ b;
                    row_bits = {row_bits[2:0], b};
                end
            end
            IN_TRAILER: begin
                frame_bits = frame_bits + 6'd1;
                group_bits = group_bits + 3'd1;
                if (group_bits <= em4mfd_pkg::COL_BITS) begin
                    col_par_rx[group_bits - 3'd1] = b;
                end else begin
                    r.column_parity_good = ~(col_par_calc ^ col_par_rx);
                    r.tag_valid = (&r.column_parity_good) && rows_ok;
                    r.tag_value = tag_acc;
                    r.event_kind = em4mfd_pkg::KIND_TRAILER;
                    tag_acc = '0;
                    group_bits = 3'd0;
                    phase = SEEK_HEADER;
                    frame_bits = 6'd0;
                    col_par_calc = '0;
                    col_par_rx = '0;
                    rows_ok = 1'b1;
                end
            end
            default: begin
                phase = SEEK_HEADER;
                if (b) begin
                    if (ones_seen != 4'd0)
                        ones_seen = ones_seen + 4'd1;
                    if (ones_seen == em4mfd_pkg::HEADER_ONES) begin
                        r.event_kind = em4mfd_pkg::KIND_HEADER;
                        ones_seen = 4'd0;
                        phase = IN_PAYLOAD;
                    end else if (ones_seen == 4'd0) begin
                        ones_seen = 4'd1;
                    end
                end else begin
                    ones_seen = 4'd0;
                end
            end
        endcase
        bits_due.push_back(r);
    endtask

    // pulse length against the half-bit limit decides whether this edge closes a bit
    task automatic decode_edge(input logic [em4mfd_pkg::TIME_W-1:0] t, input logic lvl);
        logic                          b;
        logic                          long_now;
        logic                          long_prev;
        logic [em4mfd_pkg::TIME_W-1:0] gap;
        logic [em4mfd_pkg::TIME_W-1:0] prev_mid;
        logic [em4mfd_pkg::TIME_W-1:0] prev_start;
        logic [em4mfd_pkg::TIME_W-1:0] mid_now;
        b = pol_reg ? lvl : ~lvl;
        gap = t - prev_edge_t;
        long_now = gap > limit_reg;
        long_prev = prev_gap > limit_reg;
        prev_mid = prev_edge_t - (prev_gap >> 1);
        prev_start = prev_edge_t - prev_gap;
        if (long_now) begin
            mid_now = t - (gap >> 1);
            frame_bit(b, long_prev ? prev_mid : prev_start, mid_now);
            last_bit_end = mid_now;
        end else if (long_prev) begin
            frame_bit(b, prev_mid, t);
            last_bit_end = t;
        end else if (last_bit_end <= prev_start) begin
            frame_bit(b, prev_start, t);
            last_bit_end = t;
        end
        prev_gap = gap;
        prev_edge_t = t;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bits_due.delete();
            limit_reg = em4mfd_pkg::HALF_LIMIT_RST;
            pol_reg = 1'b1;
            prev_edge_t = '0;
            prev_gap = '0;
            last_bit_end = '0;
            phase = SEEK_HEADER;
            ones_seen = '0;
            frame_bits = '0;
            group_bits = '0;
            row_bits = '0;
            row_par = 1'b0;
            col_par_calc = '0;
            col_par_rx = '0;
            rows_ok = 1'b1;
            tag_acc = '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.bit_value = i_bit_value;
                got.bit_start = i_bit_start;
                got.bit_end = i_bit_end;
                got.event_kind = i_event_kind;
                got.nibble = i_nibble;
                got.row_parity_good = i_row_parity_good;
                got.column_parity_good = i_column_parity_good;
                got.tag_value = i_tag_value;
                got.tag_valid = i_tag_valid;
                if (bits_due.size() == 0) begin
                    fails++;
                    if (reported < 10) begin
                        reported++;
                        show("unexpected result transfer", got);
                    end
                end else begin
                    want = bits_due.pop_front();
                    if (got.bit_value !== want.bit_value ||
                        got.bit_start !== want.bit_start ||
                        got.bit_end !== want.bit_end ||
                        got.event_kind !== want.event_kind ||
                        got.nibble !== want.nibble ||
                        got.row_parity_good !== want.row_parity_good ||
                        got.column_parity_good !== want.column_parity_good ||
                        got.tag_value !== want.tag_value ||
                        got.tag_valid !== want.tag_valid) begin
                        fails++;
                        if (reported < 10) begin
                            reported++;
                            show("mismatch exp", want);
                            show("mismatch got", got);
                        end
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    em4mfd_pkg::CFG_HALF_LIMIT: limit_reg = i_cfg_wdata[em4mfd_pkg::LIMIT_W-1:0];
                    em4mfd_pkg::CFG_POLARITY:   pol_reg = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                decode_edge(i_edge_time, i_new_level);
        end
        o_pending <= bits_due.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/em4100_manchester_frame_decoder_core_test.sv
module em4100_manchester_frame_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = em4mfd_pkg::TIME_W;
    localparam int CW = em4mfd_pkg::CFG_W;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;

    logic                                 clk;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [TW-1:0]                        edge_time = '0;
    logic                                 new_level = 1'b0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic                                 bit_value;
    logic [TW-1:0]                        bit_start;
    logic [TW-1:0]                        bit_end;
    logic [em4mfd_pkg::KIND_W-1:0]        event_kind;
    logic [em4mfd_pkg::NIB_W-1:0]         nibble;
    logic                                 row_par_good;
    logic [em4mfd_pkg::NIB_W-1:0]         col_par_good;
    logic [em4mfd_pkg::TAG_W-1:0]         tag_value;
    logic                                 tag_valid;
    logic                                 cfg_wr_en = 1'b0;
    logic [em4mfd_pkg::CFG_IDX_W-1:0]     cfg_index = em4mfd_pkg::CFG_HALF_LIMIT;
    logic [CW-1:0]                        cfg_wdata = '0;
    int                                   fail_count;
    int                                   pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_arm = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    int cycles = 0;
    int items_sent = 0;

    // line model used to encode manchester frames into edges
    logic [TW-1:0] line_t = '0;
    logic          line_lvl = 1'b0;
    int            run_halves = 1;
    int            half_bit = 256;
    logic          cur_pol = 1'b1;

    em4100_manchester_frame_decoder_core dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_edge_time          (edge_time),
        .i_new_level          (new_level),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_bit_value          (bit_value),
        .o_bit_start          (bit_start),
        .o_bit_end            (bit_end),
        .o_event_kind         (event_kind),
        .o_nibble             (nibble),
        .o_row_parity_good    (row_par_good),
        .o_column_parity_good (col_par_good),
        .o_tag_value          (tag_value),
        .o_tag_valid          (tag_valid),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_index          (cfg_index),
        .i_cfg_wdata          (cfg_wdata)
    );

    em4100_frame_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_edge_time          (edge_time),
        .i_new_level          (new_level),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_bit_value          (bit_value),
        .i_bit_start          (bit_start),
        .i_bit_end            (bit_end),
        .i_event_kind         (event_kind),
        .i_nibble             (nibble),
        .i_row_parity_good    (row_par_good),
        .i_column_parity_good (col_par_good),
        .i_tag_value          (tag_value),
        .i_tag_valid          (tag_valid),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_index          (cfg_index),
        .i_cfg_wdata          (cfg_wdata),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side, with one long hold-off once armed
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_edge(input logic [TW-1:0] t, input logic lvl);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        edge_time <= t;
        new_level <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CW-1:0] limit, input logic pol);
        cfg_wr_en <= 1'b1;
        cfg_index <= em4mfd_pkg::CFG_HALF_LIMIT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_index <= em4mfd_pkg::CFG_POLARITY;
        cfg_wdata <= CW'(pol);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_pol = pol;
    endtask

    // one half-bit cell on the line; an edge goes out only when the level changes
    task automatic send_half(input logic lv);
        int dur;
        if (lv == line_lvl) begin
            run_halves++;
        end else begin
            dur = run_halves * half_bit + int'($urandom_range(half_bit / 4)) - half_bit / 8;
            line_t = line_t + TW'(dur);
            line_lvl = lv;
            run_halves = 1;
            send_edge(line_t, lv);
        end
    endtask

    task automatic send_bit(input logic b);
        logic first;
        first = cur_pol ? b : ~b;
        send_half(first);
        send_half(~first);
    endtask

    task automatic send_noise(input int count, input logic wide);
        int k;
        for (k = 0; k < count; k++) begin
            if (wide)
                line_t = {16'($urandom), 32'($urandom)};
            else
                line_t = line_t + TW'($urandom_range(1, 4 * half_bit));
            if ($urandom_range(3) != 0)
                line_lvl = ~line_lvl;
            run_halves = 1;
            send_edge(line_t, line_lvl);
        end
    endtask

    // header, ten rows with even parity, column parity, stop; sometimes corrupted or cut short
    task automatic send_frame();
        logic [em4mfd_pkg::TAG_W-1:0] tag;
        logic [3:0]                   nib;
        logic [3:0]                   colx;
        logic                         frame_seq [64];
        int                           n;
        int                           k;
        int                           j;
        int                           mode;
        int                           flip_at;
        int                           cut_at;
        tag = {8'($urandom), 32'($urandom)};
        colx = '0;
        n = 0;
        for (k = 0; k < 9; k++) begin
            frame_seq[n] = 1'b1;
            n++;
        end
        for (k = 0; k < 10; k++) begin
            nib = tag[em4mfd_pkg::TAG_W-1-4*k -: 4];
            for (j = 3; j >= 0; j--) begin
                frame_seq[n] = nib[j];
                n++;
            end
            frame_seq[n] = ^nib;
            n++;
            colx = colx ^ {nib[0], nib[1], nib[2], nib[3]};
        end
        for (k = 0; k < 4; k++) begin
            frame_seq[n] = colx[k];
            n++;
        end
        frame_seq[n] = ($urandom_range(7) == 0);
        mode = $urandom_range(9);
        flip_at = (mode == 0) ? $urandom_range(9, 63) : 64;
        cut_at = (mode == 1) ? $urandom_range(1, 63) : 64;
        send_bit(1'b0);
        send_bit(1'b0);
        for (k = 0; k < cut_at; k++)
            send_bit(frame_seq[k] ^ (k == flip_at));
        if (mode == 1)
            send_noise($urandom_range(1, 8), 1'b0);
    endtask

    task automatic run_frames(input int budget);
        int start;
        start = items_sent;
        while (items_sent - start < budget) begin
            send_frame();
            if ($urandom_range(3) == 0)
                send_noise($urandom_range(1, 6), 1'b0);
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: first edge, zero gap, limit boundary, wrap, time extremes
        send_edge(48'h0000_0000_0000, 1'b1);
        send_edge(48'h0000_0000_0000, 1'b0);
        send_edge(48'h0000_0000_0180, 1'b1);
        send_edge(48'h0000_0000_0301, 1'b0);
        send_edge(48'h0000_0000_0401, 1'b1);
        send_edge(48'h0000_0000_0501, 1'b0);
        send_edge(48'h0000_0000_0701, 1'b1);
        send_edge(48'hFFFF_FFFF_FFFF, 1'b0);
        send_edge(48'h0000_0000_0005, 1'b1);
        send_edge(48'h7FFF_FFFF_FFFF, 1'b0);
        send_edge(48'h8000_0000_0000, 1'b1);
        send_edge(48'h8000_0000_0180, 1'b0);
        send_edge(48'h8000_0000_0301, 1'b1);
        send_edge(48'h8000_0000_0401, 1'b0);
        send_edge(48'h8000_0000_0501, 1'b1);
        send_edge(48'h8000_0000_0601, 1'b0);
        line_t = 48'h8000_0000_0601;
        line_lvl = 1'b0;
        drain_results();

        // sender idles lightly, receiver heavily
        tx_idle_pct = 24;
        rx_idle_pct <= 87;
        half_bit = 256;
        write_config(CW'(384), 1'b1);
        run_frames(400);
        drain_results();

        // the other way round, active-low polarity, random bit period
        tx_idle_pct = 87;
        rx_idle_pct <= 24;
        half_bit = $urandom_range(8, 1000);
        write_config(CW'(half_bit + half_bit / 2), 1'b0);
        run_frames(400);
        drain_results();

        // zero limit: every nonzero pulse is a full bit
        tx_idle_pct = 24;
        rx_idle_pct <= 87;
        write_config('0, 1'b1);
        send_noise(40, 1'b0);
        send_noise(40, 1'b1);
        drain_results();

        // largest limit
        tx_idle_pct = 87;
        rx_idle_pct <= 24;
        write_config('1, 1'b0);
        send_noise(40, 1'b1);
        send_noise(40, 1'b0);
        drain_results();

        // no idling; receiver holds off while frames keep coming
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        half_bit = 2048;
        write_config(CW'(3072), 1'b1);
        hold_arm <= 1'b1;
        run_frames(260);
        drain_results();

        // short bit period across the time wrap, with a full pause midway
        half_bit = $urandom_range(8, 64);
        write_config(CW'(half_bit + half_bit / 2), 1'b1);
        line_t = 48'hFFFF_FFFF_FFFF - TW'(100 * half_bit);
        run_frames(200);
        drain_results();
        run_frames(200);
        drain_results();

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> em4100_manchester_frame_decoder_core.f
src/em4mfd_pkg.sv
src/em4mfd_edge.sv
src/em4mfd_frame.sv
src/em4100_manchester_frame_decoder_core.sv
tb/em4100_frame_checker.sv
tb/em4100_manchester_frame_decoder_core_test.sv
